/* src/bfws_pkg.sv */
// shared types and constants for the bounded fifo with statistics
package bfws_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned CountW = 5;
  localparam int unsigned StatW  = 64;

  // request command codes
  localparam logic CmdAdd = 1'b0;
  localparam logic CmdGet = 1'b1;

  // reset value of the limit register
  localparam logic [CountW-1:0] MaxCountRst = CountW'(16);

  // controller to datapath commands
  typedef struct packed {
    logic capture;  // latch request and start head read
    logic commit;   // update queue state and load result register
  } ctrl_cmd_t;

endpackage

/* src/bfws_if.sv */
// request and result channel interfaces
interface bfws_in_if;
  import bfws_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     command;
  logic signed [DataW-1:0]  value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

interface bfws_out_if;
  import bfws_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     ok;
  logic signed [DataW-1:0]  value_out;
  logic [CountW-1:0]        count;
  logic [StatW-1:0]         add_attempts;
  logic [StatW-1:0]         get_attempts;
  logic [StatW-1:0]         add_successes;
  logic [StatW-1:0]         get_successes;

  modport source (output valid, output ok, output value_out, output count,
                  output add_attempts, output get_attempts, output add_successes,
                  output get_successes, input ready);
  modport sink   (input valid, input ok, input value_out, input count,
                  input add_attempts, input get_attempts, input add_successes,
                  input get_successes, output ready);
endinterface

/* src/bfws_ctrl.sv */
// request sequencing state machine and result valid flag
module bfws_ctrl
  import bfws_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output ctrl_cmd_t cmd_o
);

  typedef enum logic {
    StIdle,
    StExec
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   slot_free;

  // result register can take a new result this cycle
  assign slot_free = !out_valid_q || out_ready_i;

  assign in_ready_o    = (state_q == StIdle);
  assign out_valid_o   = out_valid_q;
  assign cmd_o.capture = (state_q == StIdle) && in_valid_i;
  assign cmd_o.commit  = (state_q == StExec) && slot_free;

  // state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
          if (in_valid_i) state_q <= StExec;
        end
        StExec: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

/* src/bfws_dp.sv */
// ring store, pointers, count, statistics counters and result register
module bfws_dp
  import bfws_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ctrl_cmd_t               cmd_i,
  input  logic                    max_count_we_i,
  input  logic [CountW-1:0]       max_count_i,
  input  logic                    command_i,
  input  logic signed [DataW-1:0] value_i,
  output logic                    ok_o,
  output logic signed [DataW-1:0] value_out_o,
  output logic [CountW-1:0]       count_o,
  output logic [StatW-1:0]        add_attempts_o,
  output logic [StatW-1:0]        get_attempts_o,
  output logic [StatW-1:0]        add_successes_o,
  output logic [StatW-1:0]        get_successes_o
);

  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(DEPTH - 1);

  logic signed [DataW-1:0] mem [DEPTH];

  logic [IdxW-1:0]         head_q, tail_q;
  logic [CountW-1:0]       held_q, held_d;
  logic [CountW-1:0]       max_count_q;
  logic [StatW-1:0]        add_att_q, get_att_q, add_succ_q, get_succ_q;
  logic                    cmd_q;
  logic signed [DataW-1:0] value_q;
  logic signed [DataW-1:0] rd_data_q;
  logic                    add_ok, get_ok;

  // admission checks against the limit and the physical depth
  assign add_ok = (cmd_q == CmdAdd) && (held_q < max_count_q) &&
                  ({27'd0, held_q} < 32'(DEPTH));
  assign get_ok = (cmd_q == CmdGet) && (held_q != '0);

  always_comb begin
    held_d = held_q;
    if (add_ok)      held_d = held_q + CountW'(1);
    else if (get_ok) held_d = held_q - CountW'(1);
  end

  // request capture and registered head read
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q     <= command_i;
      value_q   <= value_i;
      rd_data_q <= mem[head_q];
    end
  end

  // store write on a successful add
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && add_ok) mem[tail_q] <= value_q;
  end

  // pointers, count, limit and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      held_q      <= '0;
      max_count_q <= MaxCountRst;
      add_att_q   <= '0;
      get_att_q   <= '0;
      add_succ_q  <= '0;
      get_succ_q  <= '0;
    end else begin
      if (max_count_we_i) max_count_q <= max_count_i;
      if (cmd_i.commit) begin
        held_q <= held_d;
        if (cmd_q == CmdAdd) add_att_q <= add_att_q + StatW'(1);
        else                 get_att_q <= get_att_q + StatW'(1);
        if (add_ok) begin
          add_succ_q <= add_succ_q + StatW'(1);
          tail_q     <= (tail_q == LastIdx) ? '0 : tail_q + IdxW'(1);
        end
        if (get_ok) begin
          get_succ_q <= get_succ_q + StatW'(1);
          head_q     <= (head_q == LastIdx) ? '0 : head_q + IdxW'(1);
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      ok_o            <= add_ok || get_ok;
      value_out_o     <= get_ok ? rd_data_q : '0;
      count_o         <= held_d;
      add_attempts_o  <= (cmd_q == CmdAdd) ? add_att_q + StatW'(1) : add_att_q;
      get_attempts_o  <= (cmd_q == CmdGet) ? get_att_q + StatW'(1) : get_att_q;
      add_successes_o <= add_ok ? add_succ_q + StatW'(1) : add_succ_q;
      get_successes_o <= get_ok ? get_succ_q + StatW'(1) : get_succ_q;
    end
  end

endmodule

/* src/bounded_fifo_with_stats_top.sv */
// Bounded fifo with statistics: one result per request.
// Sequence: the request is captured, then the commit step loads the result
// register if it is free; a stalled result delays the commit step until it is taken.
// One request in flight: a new request is taken only after the commit step
// of the last one. Reset is asynchronous, active low: queue empty,
// counters zero, limit 16; store contents are undefined until written.
module bounded_fifo_with_stats_top
  import bfws_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              max_count_we_i,
  input  logic [CountW-1:0] max_count_i,
  bfws_in_if.sink           req_i,
  bfws_out_if.source        rsp_o
);

  ctrl_cmd_t cmd;

  // sequencing
  bfws_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .cmd_o       (cmd)
  );

  // queue and statistics datapath
  bfws_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .max_count_we_i  (max_count_we_i),
    .max_count_i     (max_count_i),
    .command_i       (req_i.command),
    .value_i         (req_i.value),
    .ok_o            (rsp_o.ok),
    .value_out_o     (rsp_o.value_out),
    .count_o         (rsp_o.count),
    .add_attempts_o  (rsp_o.add_attempts),
    .get_attempts_o  (rsp_o.get_attempts),
    .add_successes_o (rsp_o.add_successes),
    .get_successes_o (rsp_o.get_successes)
  );

endmodule

/* src/bfws_checker.sv */
// port-level checks for the bounded fifo with statistics
module bfws_checker
  import bfws_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_i,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input logic                    ok_i,
  input logic signed [DataW-1:0] value_out_i,
  input logic [CountW-1:0]       count_i
);

  // stalled result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(ok_i) &&
    $stable(value_out_i) && $stable(count_i))
    else $error("result changed while stalled");

  // a failed request carries a zero value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !ok_i |-> value_out_i == '0)
    else $error("nonzero value on failed request");

  // one request in flight: no request taken on the edge after one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("back-to-back request accepted");

  // count never exceeds the store depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> 32'(count_i) <= 32'(DEPTH))
    else $error("count above depth");

endmodule

bind bounded_fifo_with_stats_top bfws_checker #(
  .DEPTH (DEPTH)
) u_bfws_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (req_i.valid),
  .in_ready_i  (req_i.ready),
  .out_valid_i (rsp_o.valid),
  .out_ready_i (rsp_o.ready),
  .ok_i        (rsp_o.ok),
  .value_out_i (rsp_o.value_out),
  .count_i     (rsp_o.count)
);
